>>> sv/kect_pkg.sv
// ----------------------------------------------------------------------------
// kect_pkg
// shared types and constants of the keyed event count table
// ----------------------------------------------------------------------------
package kect_pkg;

  localparam int TYPE_W = 2;
  localparam int SIZE_W = 64;
  localparam int CNT_W  = 32;
  localparam int IDX_W  = 10;

  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  typedef struct packed {
    logic [TYPE_W-1:0] etype;
    logic [SIZE_W-1:0] esize;
    logic [CNT_W-1:0]  count;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HIT,
    ST_MISS,
    ST_RD,
    ST_RD_WAIT
  } state_t;

  typedef enum logic [1:0] {
    RES_HIT,
    RES_MISS,
    RES_READ
  } res_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     search_en;
    logic     rd_issue;
    logic     commit;
    res_sel_t res_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic search_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> sv/kect_ctrl.sv
// ----------------------------------------------------------------------------
// kect_ctrl
// sequencer for search, update, append and read of the count table
// ----------------------------------------------------------------------------
module kect_ctrl
  import kect_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       kind,
  input  dp_status_t status,
  output logic       in_stall,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (kind == KIND_READ) ? ST_RD : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.hit) begin
          state_next = ST_HIT;
        end else if (status.search_done) begin
          state_next = ST_MISS;
        end
      end
      ST_HIT, ST_MISS, ST_RD_WAIT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_RD: begin
        state_next = ST_RD_WAIT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cmd.load_item = 1'b0;
    cmd.search_en = 1'b0;
    cmd.rd_issue  = 1'b0;
    cmd.commit    = 1'b0;
    cmd.res_sel   = RES_READ;
    unique case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
      end
      ST_SEARCH: begin
        cmd.search_en = 1'b1;
      end
      ST_HIT: begin
        cmd.commit  = status.out_free;
        cmd.res_sel = RES_HIT;
      end
      ST_MISS: begin
        cmd.commit  = status.out_free;
        cmd.res_sel = RES_MISS;
      end
      ST_RD: begin
        cmd.rd_issue = 1'b1;
      end
      ST_RD_WAIT: begin
        cmd.commit  = status.out_free;
        cmd.res_sel = RES_READ;
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

>>> sv/kect_dp.sv
// ----------------------------------------------------------------------------
// kect_dp
// entry memory, search pointers, fill count and result register
// ----------------------------------------------------------------------------
module kect_dp
  import kect_pkg::*;
#(
  parameter int ENTRIES = 1024
)
(
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        status,
  input  logic [TYPE_W-1:0] event_type,
  input  logic [SIZE_W-1:0] event_size,
  input  logic [IDX_W-1:0]  read_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  entry_index,
  output logic              was_new,
  output logic              table_full,
  output logic              entry_valid,
  output logic [TYPE_W-1:0] entry_type,
  output logic [SIZE_W-1:0] entry_size,
  output logic [CNT_W-1:0]  entry_count
);

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  entry_t mem [ENTRIES];

  logic [TYPE_W-1:0] item_type;
  logic [SIZE_W-1:0] item_size;
  logic [IDX_W-1:0]  item_ridx;
  logic [CW-1:0]     used;
  logic [CW-1:0]     issue_ptr;
  logic              cmp_valid;
  logic [IW-1:0]     cmp_ptr;
  entry_t            rd_data;

  logic              hit_now;
  logic              issue;
  logic              rd_ok;
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  entry_t            wr_data;
  logic              full;
  logic [CW+IDX_W-1:0] ridx_w;
  logic [CW+IDX_W-1:0] used_w;
  logic [IW+IDX_W-1:0] cmp_ptr_w;
  logic [IW+IDX_W-1:0] used_ptr_w;
  logic [CNT_W-1:0]  count_inc;

  logic [IDX_W-1:0]  entry_index_next;
  logic              was_new_next;
  logic              table_full_next;
  logic              entry_valid_next;
  logic [TYPE_W-1:0] entry_type_next;
  logic [SIZE_W-1:0] entry_size_next;
  logic [CNT_W-1:0]  entry_count_next;

  assign hit_now = cmp_valid && (rd_data.etype == item_type) && (rd_data.esize == item_size);
  assign issue   = cmd.search_en && !hit_now && (issue_ptr != used);
  assign ridx_w  = {{CW{1'b0}}, item_ridx};
  assign used_w  = {{IDX_W{1'b0}}, used};
  assign rd_ok   = ridx_w < used_w;
  assign rd_en   = issue || (cmd.rd_issue && rd_ok);
  assign rd_addr = cmd.rd_issue ? ridx_w[IW-1:0] : issue_ptr[IW-1:0];
  assign full    = used == CW'(ENTRIES);

  assign cmp_ptr_w  = {{IDX_W{1'b0}}, cmp_ptr};
  assign used_ptr_w = {{IDX_W{1'b0}}, used[IW-1:0]};
  assign count_inc  = (rd_data.count == '1) ? rd_data.count : rd_data.count + CNT_W'(1);

  assign status.hit         = hit_now;
  assign status.search_done = !cmp_valid && (issue_ptr == used);
  assign status.out_free    = !out_valid || !out_stall;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cmp_ptr;
    wr_data = '{etype: item_type, esize: item_size, count: count_inc};
    case (cmd.res_sel)
      RES_HIT: begin
        wr_en = cmd.commit;
      end
      RES_MISS: begin
        wr_en         = cmd.commit && !full;
        wr_addr       = used[IW-1:0];
        wr_data.count = CNT_W'(1);
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_type <= event_type;
      item_size <= event_size;
      item_ridx <= read_index;
      issue_ptr <= '0;
    end else if (issue) begin
      issue_ptr <= issue_ptr + CW'(1);
      cmp_ptr   <= issue_ptr[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
      used      <= '0;
    end else begin
      cmp_valid <= issue;
      if (cmd.commit && cmd.res_sel == RES_MISS && !full) begin
        used <= used + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    entry_index_next = '0;
    was_new_next     = 1'b0;
    table_full_next  = 1'b0;
    entry_valid_next = 1'b0;
    entry_type_next  = '0;
    entry_size_next  = '0;
    entry_count_next = '0;
    case (cmd.res_sel)
      RES_HIT: begin
        entry_index_next = cmp_ptr_w[IDX_W-1:0];
      end
      RES_MISS: begin
        if (full) begin
          table_full_next = 1'b1;
        end else begin
          entry_index_next = used_ptr_w[IDX_W-1:0];
          was_new_next     = 1'b1;
        end
      end
      default: begin
        entry_index_next = item_ridx;
        if (rd_ok) begin
          entry_valid_next = 1'b1;
          entry_type_next  = rd_data.etype;
          entry_size_next  = rd_data.esize;
          entry_count_next = rd_data.count;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      entry_index <= entry_index_next;
      was_new     <= was_new_next;
      table_full  <= table_full_next;
      entry_valid <= entry_valid_next;
      entry_type  <= entry_type_next;
      entry_size  <= entry_size_next;
      entry_count <= entry_count_next;
    end
  end

endmodule

>>> sv/keyed_event_count_table_top.sv
// ----------------------------------------------------------------------------
// keyed_event_count_table_top
// fill-ordered table of (event type, size) keys with saturating hit counts
// ----------------------------------------------------------------------------
// One item is handled at a time. A record item scans the used entries from
// position 0 through the entry memory's read port, one entry per cycle: a
// hit stops the scan and updates that entry, a miss is known once every used
// entry has been compared and appends a new entry unless the table is full.
// A read item reads the entry at read_index. The next item is taken in the
// cycle after the result is registered. The result register lets the next
// item enter while a result still waits to be taken; that item then holds
// until the register is free. No clearing is needed after reset.
module keyed_event_count_table_top
  import kect_pkg::*;
#(
  parameter int ENTRIES = 1024
)
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              kind,
  input  logic [TYPE_W-1:0] event_type,
  input  logic [SIZE_W-1:0] event_size,
  input  logic [IDX_W-1:0]  read_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [IDX_W-1:0]  entry_index,
  output logic              was_new,
  output logic              table_full,
  output logic              entry_valid,
  output logic [TYPE_W-1:0] entry_type,
  output logic [SIZE_W-1:0] entry_size,
  output logic [CNT_W-1:0]  entry_count
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  kect_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  kect_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .event_type  (event_type),
    .event_size  (event_size),
    .read_index  (read_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .entry_index (entry_index),
    .was_new     (was_new),
    .table_full  (table_full),
    .entry_valid (entry_valid),
    .entry_type  (entry_type),
    .entry_size  (entry_size),
    .entry_count (entry_count)
  );

endmodule
